[design/utfv_pkg.sv]
package utfv_pkg;

    // Largest text length after reset; the length register is 13 bits wide.
    localparam int MAX_TEXT_BYTES = 4096;
    localparam int LEN_W          = 13;
    localparam logic [LEN_W-1:0] COUNT_CAP   = '1;
    localparam logic [LEN_W-1:0] LIMIT_RESET =
        (MAX_TEXT_BYTES > 8191) ? COUNT_CAP : LEN_W'(MAX_TEXT_BYTES);

    // Depth of the queue between the front and back ends.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Result reason codes.
    localparam logic [3:0] RSN_OK      = 4'd0;
    localparam logic [3:0] RSN_EMPTY   = 4'd1;
    localparam logic [3:0] RSN_LONG    = 4'd2;
    localparam logic [3:0] RSN_LEAD    = 4'd3;
    localparam logic [3:0] RSN_CONT    = 4'd4;
    localparam logic [3:0] RSN_TRUNC   = 4'd5;
    localparam logic [3:0] RSN_SCALAR  = 4'd6;
    localparam logic [3:0] RSN_CONTROL = 4'd7;
    localparam logic [3:0] RSN_SPACE   = 4'd8;

    // Byte classes as seen by the front end.
    typedef enum logic [2:0] {
        CLS_ASCII,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_CONT,
        CLS_BAD
    } t_byte_cls;

    // One classified input transaction as it travels through the queue.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
        logic       no_byte;
        t_byte_cls  cls;
    } t_item;

    // True for the Unicode whitespace scalars.
    function automatic logic is_space(input logic [20:0] cp);
        logic sp;
        sp = (cp == 21'h20) || (cp == 21'ha0) || (cp == 21'h1680) ||
             (cp >= 21'h2000 && cp <= 21'h200a) || (cp == 21'h2028) ||
             (cp == 21'h2029) || (cp == 21'h202f) || (cp == 21'h205f) ||
             (cp == 21'h3000);
        return sp;
    endfunction

    // True for overlong forms, surrogates and values beyond the code space.
    function automatic logic is_bad_scalar(input logic [20:0] cp, input logic [1:0] trail);
        logic bad;
        bad = (trail == 2'd2 && cp < 21'h800) || (trail == 2'd3 && cp < 21'h10000) ||
              (cp >= 21'hd800 && cp <= 21'hdfff) || (cp > 21'h10ffff);
        return bad;
    endfunction

    // True for C0 controls, DEL and C1 controls.
    function automatic logic is_control(input logic [20:0] cp);
        logic ctl;
        ctl = (cp <= 21'h1f) || (cp >= 21'h7f && cp <= 21'h9f);
        return ctl;
    endfunction

endpackage

[design/utfv_front.sv]
module utfv_front (
    input  logic             i_push,
    input  logic [7:0]       i_data_byte,
    input  logic             i_last,
    input  logic             i_no_byte,
    input  logic             i_q_full,
    output logic             o_q_push,
    output utfv_pkg::t_item  o_item
);

    // A transaction enters whenever the queue has room.
    assign o_q_push = i_push && !i_q_full;

    // Classify the byte by its leading bits and lead range.
    always_comb begin
        o_item.data_byte = i_data_byte;
        o_item.last      = i_last;
        o_item.no_byte   = i_no_byte;
        if (i_data_byte <= 8'h7f) begin
            o_item.cls = utfv_pkg::CLS_ASCII;
        end else if (i_data_byte <= 8'hbf) begin
            o_item.cls = utfv_pkg::CLS_CONT;
        end else if (i_data_byte >= 8'hc2 && i_data_byte <= 8'hdf) begin
            o_item.cls = utfv_pkg::CLS_LEAD2;
        end else if (i_data_byte >= 8'he0 && i_data_byte <= 8'hef) begin
            o_item.cls = utfv_pkg::CLS_LEAD3;
        end else if (i_data_byte >= 8'hf0 && i_data_byte <= 8'hf4) begin
            o_item.cls = utfv_pkg::CLS_LEAD4;
        end else begin
            o_item.cls = utfv_pkg::CLS_BAD;
        end
    end

endmodule

[design/utfv_queue.sv]
module utfv_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  utfv_pkg::t_item  i_item,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output utfv_pkg::t_item  o_item
);

    utfv_pkg::t_item                 r_mem [utfv_pkg::QUEUE_DEPTH];
    logic [utfv_pkg::QPTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [utfv_pkg::QPTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [utfv_pkg::QCNT_W-1:0]     r_count, n_count;
    logic                            push_en;
    logic                            pop_en;

    localparam logic [utfv_pkg::QPTR_W-1:0] PTR_LAST =
        utfv_pkg::QPTR_W'(utfv_pkg::QUEUE_DEPTH - 1);
    localparam logic [utfv_pkg::QCNT_W-1:0] CNT_FULL =
        utfv_pkg::QCNT_W'(utfv_pkg::QUEUE_DEPTH);

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign push_en = i_push && !o_full;
    assign pop_en  = i_pop && o_valid;

    // Pointer and occupancy update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push_en && !pop_en) begin
            n_count = r_count + 1'b1;
        end else if (pop_en && !push_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

[design/utfv_back.sv]
module utfv_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [utfv_pkg::LEN_W-1:0]  i_cfg_wdata,
    input  logic                        i_q_valid,
    input  utfv_pkg::t_item             i_item,
    output logic                        o_q_pop,
    input  logic                        i_pop,
    output logic                        o_res_valid,
    output logic [3:0]                  o_reason
);

    logic [utfv_pkg::LEN_W-1:0] r_max_bytes;
    logic [1:0]                 r_left, n_left;
    logic [1:0]                 r_seq, n_seq;
    logic [20:0]                r_acc, n_acc;
    logic [utfv_pkg::LEN_W-1:0] r_count, n_count;
    logic [3:0]                 r_err, n_err;
    logic                       r_vis, n_vis;
    logic                       r_out_valid, n_out_valid;
    logic [3:0]                 r_reason, n_reason;

    logic                       take;
    logic                       fin;
    logic [20:0]                fin_cp;
    logic [1:0]                 fin_trail;
    logic [20:0]                acc_shift;

    // A closing transaction waits until the result register is free or being read.
    assign take        = i_q_valid && (!i_item.last || !r_out_valid || i_pop);
    assign o_q_pop     = take;
    assign o_res_valid = r_out_valid;
    assign o_reason    = r_reason;
    assign acc_shift   = {r_acc[14:0], i_item.data_byte[5:0]};

    // Sequence decoding, scalar checks and result formation.
    always_comb begin
        n_left      = r_left;
        n_seq       = r_seq;
        n_acc       = r_acc;
        n_count     = r_count;
        n_err       = r_err;
        n_vis       = r_vis;
        n_out_valid = r_out_valid;
        n_reason    = r_reason;
        fin         = 1'b0;
        fin_cp      = '0;
        fin_trail   = '0;

        if (i_pop && r_out_valid) begin
            n_out_valid = 1'b0;
        end

        if (take && !i_item.no_byte) begin
            if (r_count != utfv_pkg::COUNT_CAP) begin
                n_count = r_count + 1'b1;
            end
            if (r_err == utfv_pkg::RSN_OK) begin
                if (r_left == 2'd0) begin
                    case (i_item.cls)
                        utfv_pkg::CLS_ASCII: begin
                            fin    = 1'b1;
                            fin_cp = {13'd0, i_item.data_byte};
                        end
                        utfv_pkg::CLS_LEAD2: begin
                            n_acc  = {16'd0, i_item.data_byte[4:0]};
                            n_left = 2'd1;
                            n_seq  = 2'd1;
                        end
                        utfv_pkg::CLS_LEAD3: begin
                            n_acc  = {17'd0, i_item.data_byte[3:0]};
                            n_left = 2'd2;
                            n_seq  = 2'd2;
                        end
                        utfv_pkg::CLS_LEAD4: begin
                            n_acc  = {18'd0, i_item.data_byte[2:0]};
                            n_left = 2'd3;
                            n_seq  = 2'd3;
                        end
                        default: begin
                            n_err = utfv_pkg::RSN_LEAD;
                        end
                    endcase
                end else if (i_item.cls != utfv_pkg::CLS_CONT) begin
                    n_err  = utfv_pkg::RSN_CONT;
                    n_left = 2'd0;
                end else begin
                    n_acc  = acc_shift;
                    n_left = r_left - 1'b1;
                    if (r_left == 2'd1) begin
                        fin       = 1'b1;
                        fin_cp    = acc_shift;
                        fin_trail = r_seq;
                    end
                end
            end
        end

        // A completed scalar is checked here.
        if (fin) begin
            if (utfv_pkg::is_bad_scalar(fin_cp, fin_trail)) begin
                n_err = utfv_pkg::RSN_SCALAR;
            end else if (utfv_pkg::is_control(fin_cp)) begin
                n_err = utfv_pkg::RSN_CONTROL;
            end else if (!utfv_pkg::is_space(fin_cp)) begin
                n_vis = 1'b1;
            end
        end

        // The closing transaction produces the verdict and clears the text state.
        if (take && i_item.last) begin
            n_out_valid = 1'b1;
            if (n_count > r_max_bytes) begin
                n_reason = utfv_pkg::RSN_LONG;
            end else if (n_count == '0) begin
                n_reason = utfv_pkg::RSN_EMPTY;
            end else if (n_err != utfv_pkg::RSN_OK) begin
                n_reason = n_err;
            end else if (n_left != 2'd0) begin
                n_reason = utfv_pkg::RSN_TRUNC;
            end else if (!n_vis) begin
                n_reason = utfv_pkg::RSN_SPACE;
            end else begin
                n_reason = utfv_pkg::RSN_OK;
            end
            n_left  = '0;
            n_seq   = '0;
            n_acc   = '0;
            n_count = '0;
            n_err   = utfv_pkg::RSN_OK;
            n_vis   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes <= utfv_pkg::LIMIT_RESET;
            r_left      <= '0;
            r_seq       <= '0;
            r_acc       <= '0;
            r_count     <= '0;
            r_err       <= utfv_pkg::RSN_OK;
            r_vis       <= 1'b0;
            r_out_valid <= 1'b0;
            r_reason    <= utfv_pkg::RSN_OK;
        end else begin
            if (i_cfg_we) begin
                r_max_bytes <= i_cfg_wdata;
            end
            r_left      <= n_left;
            r_seq       <= n_seq;
            r_acc       <= n_acc;
            r_count     <= n_count;
            r_err       <= n_err;
            r_vis       <= n_vis;
            r_out_valid <= n_out_valid;
            r_reason    <= n_reason;
        end
    end

endmodule

[design/utf8_text_validator_unit.sv]
// Strict UTF-8 text checker.
// Input channel: a text arrives as one transaction per byte on i_data_byte,
// with i_last on its final transaction. A transaction with i_no_byte set
// carries no byte; with i_last it closes the text, which makes a
// zero-length text when nothing came before. A transaction is taken at a
// clock edge where push is high and full is low.
// Result channel: one transaction per text, o_valid_res and o_reason, shown
// while empty is low and taken at an edge where pop is high.
// With the queue empty, the last input transaction of a text is written into
// a queue entry first; its result shows once the decoder has consumed it.
// Throughput: one byte per cycle unless a closing transaction waits on a result.
// A four-entry queue separates input from decoding, and a one-entry result
// register separates decoding from the result side, so input keeps flowing
// while a result waits. When the result receiver stalls, the decoder keeps
// consuming bytes and halts only at the next closing transaction; the queue
// then fills and full rises.
// i_cfg_we writes the maximum text length from i_cfg_wdata; write it only
// while no text is in flight. Reset empties the queue, drops any pending
// result, clears the text state and sets the length limit to 4096.
module utf8_text_validator_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [utfv_pkg::LEN_W-1:0]  i_cfg_wdata,
    input  logic                        push,
    output logic                        full,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_last,
    input  logic                        i_no_byte,
    output logic                        empty,
    input  logic                        pop,
    output logic                        o_valid_res,
    output logic [3:0]                  o_reason
);

    utfv_pkg::t_item wr_item;
    utfv_pkg::t_item head_item;
    logic            q_push;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;
    logic            res_valid;

    utfv_front u_front (
        .i_push      (push),
        .i_data_byte (i_data_byte),
        .i_last      (i_last),
        .i_no_byte   (i_no_byte),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_item      (wr_item)
    );

    utfv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (wr_item),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (head_item)
    );

    utfv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .i_item      (head_item),
        .o_q_pop     (q_pop),
        .i_pop       (pop),
        .o_res_valid (res_valid),
        .o_reason    (o_reason)
    );

    assign full        = q_full;
    assign empty       = !res_valid;
    assign o_valid_res = (o_reason == utfv_pkg::RSN_OK);

`ifndef ASSERT_OFF
    // The decoder never consumes from an empty queue.
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("decoder consumed from an empty queue");

    // A closing transaction is consumed only when the result register can take it.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_pop && head_item.last && !empty) |-> pop)
        else $error("pending result overwritten");

    // A consumed closing transaction always yields a result on the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_pop && head_item.last) |=> !empty)
        else $error("closing transaction produced no result");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result pending after reset");
`endif

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
module tb;

    // Cycles without any transaction on either side before the run is abandoned.
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic       ok;
        logic [3:0] why;
    } t_verdict;

    typedef struct packed {
        logic [7:0] data;
        logic       no_byte;
    } t_text_item;

    // Kinds of scalar that the random text builder can emit.
    typedef enum int {
        PICK_ASCII,
        PICK_SPACE,
        PICK_TWO,
        PICK_THREE,
        PICK_FOUR,
        PICK_CTRL,
        PICK_OVERLONG,
        PICK_SURROGATE,
        PICK_HIGH,
        PICK_STRAY,
        PICK_BROKEN,
        PICK_NULL
    } t_pick;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_cfg_we    = 1'b0;
    logic [utfv_pkg::LEN_W-1:0] i_cfg_wdata = '0;
    logic                       push        = 1'b0;
    logic                       full;
    logic [7:0]                 i_data_byte = '0;
    logic                       i_last      = 1'b0;
    logic                       i_no_byte   = 1'b0;
    logic                       empty;
    logic                       pop         = 1'b0;
    logic                       o_valid_res;
    logic [3:0]                 o_reason;

    utf8_text_validator_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .push        (push),
        .full        (full),
        .i_data_byte (i_data_byte),
        .i_last      (i_last),
        .i_no_byte   (i_no_byte),
        .empty       (empty),
        .pop         (pop),
        .o_valid_res (o_valid_res),
        .o_reason    (o_reason)
    );

    always #5 i_clk = ~i_clk;

    // Predicted decoder state and the length limit it is checked against.
    logic [utfv_pkg::LEN_W-1:0] len_limit = utfv_pkg::LIMIT_RESET;
    logic [1:0]                 pend_cont;
    logic [1:0]                 seq_trail;
    logic [20:0]                cp_acc;
    logic [utfv_pkg::LEN_W-1:0] text_len;
    logic [3:0]                 err_code;
    logic                       has_visible;

    t_verdict   verdicts_due[$];
    t_text_item text_items[$];

    int fail_count   = 0;
    int burst_left   = 0;
    int items_sent   = 0;
    int bytes_taken  = 0;
    int nulls_taken  = 0;
    int texts_closed = 0;
    int idle_cycles  = 0;
    int rx_tick      = 0;
    int rx_mode      = 0;
    int reason_tally[16];

    function automatic logic blank_scalar(input logic [20:0] cp);
        logic hit;
        hit = 1'b0;
        case (cp)
            21'h20, 21'ha0, 21'h1680, 21'h2028, 21'h2029, 21'h202f, 21'h205f, 21'h3000: begin
                hit = 1'b1;
            end
            default: begin
                hit = (cp >= 21'h2000) && (cp <= 21'h200a);
            end
        endcase
        return hit;
    endfunction

    task automatic clear_text_state();
        pend_cont   = 2'd0;
        seq_trail   = 2'd0;
        cp_acc      = '0;
        text_len    = '0;
        err_code    = utfv_pkg::RSN_OK;
        has_visible = 1'b0;
    endtask

    // A completed scalar is range checked, then control checked, then classed.
    task automatic close_scalar(input logic [20:0] cp, input logic [1:0] trail);
        if ((trail == 2'd2 && cp < 21'h800) || (trail == 2'd3 && cp < 21'h10000) ||
            (cp >= 21'hd800 && cp <= 21'hdfff) || cp > 21'h10ffff) begin
            err_code = utfv_pkg::RSN_SCALAR;
        end else if (cp <= 21'h1f || (cp >= 21'h7f && cp <= 21'h9f)) begin
            err_code = utfv_pkg::RSN_CONTROL;
        end else if (!blank_scalar(cp)) begin
            has_visible = 1'b1;
        end
    endtask

    // Bytes after the first decoding failure are counted but not decoded.
    task automatic absorb_byte(input logic [7:0] b);
        if (text_len != '1) text_len++;
        if (err_code == utfv_pkg::RSN_OK) begin
            if (pend_cont == 2'd0) begin
                if (!b[7]) begin
                    close_scalar({13'd0, b}, 2'd0);
                end else if (b >= 8'hc2 && b <= 8'hdf) begin
                    cp_acc    = {16'd0, b[4:0]};
                    pend_cont = 2'd1;
                    seq_trail = 2'd1;
                end else if (b >= 8'he0 && b <= 8'hef) begin
                    cp_acc    = {17'd0, b[3:0]};
                    pend_cont = 2'd2;
                    seq_trail = 2'd2;
                end else if (b >= 8'hf0 && b <= 8'hf4) begin
                    cp_acc    = {18'd0, b[2:0]};
                    pend_cont = 2'd3;
                    seq_trail = 2'd3;
                end else begin
                    err_code = utfv_pkg::RSN_LEAD;
                end
            end else if (b[7:6] != 2'b10) begin
                err_code  = utfv_pkg::RSN_CONT;
                pend_cont = 2'd0;
            end else begin
                cp_acc = {cp_acc[14:0], b[5:0]};
                pend_cont--;
                if (pend_cont == 2'd0) close_scalar(cp_acc, seq_trail);
            end
        end
    endtask

    // Advance the prediction by one accepted transaction; a closing one yields a verdict.
    task automatic predict_item(input logic [7:0] b, input logic lst, input logic nb);
        t_verdict v;
        if (!nb) absorb_byte(b);
        if (lst) begin
            if (text_len > len_limit) v.why = utfv_pkg::RSN_LONG;
            else if (text_len == '0) v.why = utfv_pkg::RSN_EMPTY;
            else if (err_code != utfv_pkg::RSN_OK) v.why = err_code;
            else if (pend_cont != 2'd0) v.why = utfv_pkg::RSN_TRUNC;
            else if (!has_visible) v.why = utfv_pkg::RSN_SPACE;
            else v.why = utfv_pkg::RSN_OK;
            v.ok = (v.why == utfv_pkg::RSN_OK);
            verdicts_due.insert(verdicts_due.size(), v);
            reason_tally[v.why]++;
            texts_closed++;
            clear_text_state();
        end
    endtask

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("MISMATCH at %0t ns: %s", $time, msg);
    endfunction

    // Sender: bursts of random length separated by random gaps.
    task automatic send_item(input logic [7:0] b, input logic lst, input logic nb);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                push <= 1'b0;
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        @(negedge i_clk);
        push        <= 1'b1;
        i_data_byte <= nb ? 8'($urandom) : b;
        i_last      <= lst;
        i_no_byte   <= nb;
        do @(posedge i_clk); while (full);
        predict_item(b, lst, nb);
        if (nb) nulls_taken++;
        else bytes_taken++;
        if (!nb || lst) items_sent++;
    endtask

    task automatic idle_sender();
        @(negedge i_clk);
        push <= 1'b0;
    endtask

    // Hold input until every verdict has come back, then let the pipeline settle.
    task automatic drain_results();
        idle_sender();
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [utfv_pkg::LEN_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        len_limit = value;
    endtask

    // Sends n bytes, most significant first; optionally closes with a byte-less item.
    task automatic send_packed(input logic [31:0] w, input int n, input bit close_nb);
        int i;
        for (i = 0; i < n; i++) send_item(w[8*(n-1-i) +: 8], (i == n - 1) && !close_nb, 1'b0);
        if (close_nb) send_item(8'($urandom), 1'b1, 1'b1);
    endtask

    task automatic send_text();
        int k;
        for (k = 0; k < text_items.size(); k++) begin
            send_item(text_items[k].data, k == text_items.size() - 1, text_items[k].no_byte);
        end
    endtask

    function automatic void add_byte(input logic [7:0] b, input logic nb);
        t_text_item it;
        it.data    = b;
        it.no_byte = nb;
        text_items.insert(text_items.size(), it);
    endfunction

    // Encodes a scalar in n bytes; a short scalar in many bytes gives an overlong form.
    function automatic void add_scalar(input logic [20:0] cp, input int n);
        case (n)
            1: begin
                add_byte(cp[7:0], 1'b0);
            end
            2: begin
                add_byte({3'b110, cp[10:6]}, 1'b0);
                add_byte({2'b10, cp[5:0]}, 1'b0);
            end
            3: begin
                add_byte({4'b1110, cp[15:12]}, 1'b0);
                add_byte({2'b10, cp[11:6]}, 1'b0);
                add_byte({2'b10, cp[5:0]}, 1'b0);
            end
            default: begin
                add_byte({5'b11110, cp[20:18]}, 1'b0);
                add_byte({2'b10, cp[17:12]}, 1'b0);
                add_byte({2'b10, cp[11:6]}, 1'b0);
                add_byte({2'b10, cp[5:0]}, 1'b0);
            end
        endcase
    endfunction

    function automatic int natural_len(input logic [20:0] cp);
        if (cp < 21'h80) return 1;
        if (cp < 21'h800) return 2;
        if (cp < 21'h10000) return 3;
        return 4;
    endfunction

    function automatic logic [20:0] pick_space();
        case ($urandom_range(0, 8))
            0: return 21'h20;
            1: return 21'ha0;
            2: return 21'h1680;
            3: return 21'h2000 + 21'($urandom_range(0, 10));
            4: return 21'h2028;
            5: return 21'h2029;
            6: return 21'h202f;
            7: return 21'h205f;
            default: return 21'h3000;
        endcase
    endfunction

    function automatic t_pick choose_pick(input bit allow_bad);
        int roll;
        t_pick p;
        roll = $urandom_range(0, 99);
        if (roll < 30) p = PICK_ASCII;
        else if (roll < 38) p = PICK_SPACE;
        else if (roll < 52) p = PICK_TWO;
        else if (roll < 64) p = PICK_THREE;
        else if (roll < 72) p = PICK_FOUR;
        else if (roll < 76) p = PICK_CTRL;
        else if (roll < 79) p = PICK_OVERLONG;
        else if (roll < 81) p = PICK_SURROGATE;
        else if (roll < 83) p = PICK_HIGH;
        else if (roll < 86) p = PICK_STRAY;
        else if (roll < 89) p = PICK_BROKEN;
        else if (roll < 93) p = PICK_NULL;
        else p = PICK_ASCII;
        if (!allow_bad && p inside {PICK_CTRL, PICK_OVERLONG, PICK_SURROGATE, PICK_HIGH,
                                    PICK_STRAY, PICK_BROKEN}) p = PICK_ASCII;
        return p;
    endfunction

    // Builds one random text: mostly well formed, some whitespace-only, empty or broken.
    task automatic build_text();
        int shape;
        int n_scal;
        int k;
        int conts;
        t_pick pick;
        logic [20:0] cp;
        logic [7:0] lead;
        bit allow_bad;
        text_items.delete();
        shape     = $urandom_range(0, 99);
        n_scal    = (shape < 4) ? 0 : $urandom_range(1, 8);
        allow_bad = (shape >= 60);
        for (k = 0; k < n_scal; k++) begin
            pick = (shape < 14) ? PICK_SPACE : choose_pick(allow_bad);
            case (pick)
                PICK_ASCII: add_scalar(21'($urandom_range(8'h21, 8'h7e)), 1);
                PICK_SPACE: begin
                    cp = pick_space();
                    add_scalar(cp, natural_len(cp));
                end
                PICK_TWO: add_scalar(21'($urandom_range(21'h80, 21'h7ff)), 2);
                PICK_THREE: add_scalar(21'($urandom_range(21'h800, 21'hffff)), 3);
                PICK_FOUR: add_scalar(21'($urandom_range(21'h10000, 21'h10ffff)), 4);
                PICK_CTRL: begin
                    cp = ($urandom_range(0, 4) == 0) ? 21'h7f : 21'($urandom_range(0, 31));
                    add_scalar(cp, 1);
                end
                PICK_OVERLONG: begin
                    case ($urandom_range(0, 2))
                        0: add_scalar(21'($urandom_range(0, 21'h7f)), 2);
                        1: add_scalar(21'($urandom_range(0, 21'h7ff)), 3);
                        default: add_scalar(21'($urandom_range(0, 21'hffff)), 4);
                    endcase
                end
                PICK_SURROGATE: add_scalar(21'($urandom_range(21'hd800, 21'hdfff)), 3);
                PICK_HIGH: add_scalar(21'($urandom_range(21'h110000, 21'h1fffff)), 4);
                PICK_STRAY: add_byte(8'($urandom), 1'b0);
                PICK_BROKEN: begin
                    add_byte(8'($urandom_range(8'hc2, 8'hf4)), 1'b0);
                    if ($urandom_range(0, 1) == 0) add_byte(8'($urandom_range(0, 8'h7f)), 1'b0);
                    else add_byte(8'($urandom_range(8'hc0, 8'hff)), 1'b0);
                end
                default: add_byte(8'($urandom), 1'b1);
            endcase
        end
        // Occasionally leave a sequence open at the end of the text.
        if (n_scal > 0 && $urandom_range(0, 9) == 0) begin
            lead  = 8'($urandom_range(8'hc2, 8'hf4));
            conts = (lead >= 8'hf0) ? $urandom_range(0, 2) : (lead >= 8'he0) ?
                    $urandom_range(0, 1) : 0;
            add_byte(lead, 1'b0);
            repeat (conts) add_byte(8'($urandom_range(8'h80, 8'hbf)), 1'b0);
        end
        if (text_items.size() == 0 || $urandom_range(0, 6) == 0) add_byte(8'($urandom), 1'b1);
    endtask

    task automatic build_long_text(input int n);
        text_items.delete();
        repeat (n) add_byte(8'($urandom_range(8'h21, 8'h7e)), 1'b0);
    endtask

    // Every named corner of the decoder, one short text each, at the reset limit.
    task automatic test_directed_cases();
        send_packed(32'h41, 1, 1'b0);           // single visible letter
        send_packed(32'h0, 0, 1'b1);            // zero-length text
        send_packed(32'h20, 1, 1'b0);           // only a space
        send_packed(32'h00, 1, 1'b0);           // NUL control
        send_packed(32'h7f, 1, 1'b0);           // DEL
        send_packed(32'hc29f, 2, 1'b0);         // C1 control
        send_packed(32'he08080, 3, 1'b0);       // overlong that is also a control
        send_packed(32'heda080, 3, 1'b0);       // surrogate
        send_packed(32'hf4908080, 4, 1'b0);     // beyond the code space
        send_packed(32'hf48fbfbf, 4, 1'b0);     // largest legal scalar
        send_packed(32'hc1, 1, 1'b0);           // forbidden lead
        send_packed(32'hff41, 2, 1'b0);         // bytes after a failure are only counted
        send_packed(32'he241, 2, 1'b0);         // broken sequence wins over truncation
        send_packed(32'he282, 2, 1'b0);         // text ends inside a sequence
        send_packed(32'he2, 1, 1'b1);           // byte-less close with a sequence open
        // A byte-less item in mid text is ignored.
        send_item(8'h41, 1'b0, 1'b0);
        send_item(8'($urandom), 1'b0, 1'b1);
        send_item(8'($urandom), 1'b1, 1'b1);
        drain_results();
    endtask

    // The length check against the smallest, a small and a medium limit.
    task automatic test_length_limits();
        cfg_write(utfv_pkg::LEN_W'(1));
        send_packed(32'h41, 1, 1'b0);
        send_packed(32'h4142, 2, 1'b0);
        send_packed(32'h0, 0, 1'b1);
        send_packed(32'hffff, 2, 1'b0);
        send_packed(32'hc2, 1, 1'b0);
        drain_results();
        cfg_write(utfv_pkg::LEN_W'(2));
        send_packed(32'he282ac, 3, 1'b0);
        send_packed(32'hc3a9, 2, 1'b0);
        drain_results();
        cfg_write(utfv_pkg::LEN_W'(100));
        build_long_text(100);
        send_text();
        build_long_text(101);
        send_text();
        drain_results();
    endtask

    // Random texts in phases, each at its own length limit.
    task automatic test_random_texts();
        int limits[4];
        int budgets[4];
        int phase;
        int start;
        bit paused;
        limits  = '{4096, $urandom_range(6, 24), 1, $urandom_range(2, 4096)};
        budgets = '{220, 180, 50, 150};
        paused  = 1'b0;
        for (phase = 0; phase < 4; phase++) begin
            cfg_write(utfv_pkg::LEN_W'(limits[phase]));
            start = items_sent;
            while (items_sent - start < budgets[phase]) begin
                build_text();
                send_text();
                if (phase == 0 && !paused && items_sent - start > budgets[phase] / 2) begin
                    drain_results();
                    paused = 1'b1;
                end
            end
            drain_results();
        end
    endtask

    // Result receiver with its own stall pattern, chosen at random from four modes.
    always @(negedge i_clk) begin
        if (rx_tick % 200 == 0) rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0: pop <= 1'b1;
            1: pop <= 1'($urandom_range(0, 1));
            2: pop <= ($urandom_range(0, 7) == 0);
            default: pop <= ((rx_tick % 24) >= 20);
        endcase
        rx_tick++;
    end

    // Compare each result transaction with the oldest pending verdict.
    always @(posedge i_clk) begin : check_result
        t_verdict due;
        if (i_rst_n && pop && !empty) begin
            if (verdicts_due.size() == 0) begin
                note_failure($sformatf("unexpected result valid=%0b reason=%0d",
                                       o_valid_res, o_reason));
            end else begin
                due = verdicts_due.pop_front();
                if (o_valid_res !== due.ok || o_reason !== due.why) begin
                    note_failure($sformatf(
                        "expected valid=%0b reason=%0d, got valid=%0b reason=%0d",
                        due.ok, due.why, o_valid_res, o_reason));
                end
            end
        end
    end

    // Watchdog on transactions at either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles, %0d verdicts pending",
                     STALL_LIMIT, verdicts_due.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        clear_text_state();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_length_limits();
        test_random_texts();
        drain_results();
        repeat (10) @(posedge i_clk);
        $display("Covered %0d texts from %0d bytes and %0d byte-less items, limits 1 to 4096.",
                 texts_closed, bytes_taken, nulls_taken);
        $write("Verdicts: ok %0d empty %0d long %0d lead %0d cont %0d",
               reason_tally[utfv_pkg::RSN_OK], reason_tally[utfv_pkg::RSN_EMPTY],
               reason_tally[utfv_pkg::RSN_LONG], reason_tally[utfv_pkg::RSN_LEAD],
               reason_tally[utfv_pkg::RSN_CONT]);
        $display(" trunc %0d scalar %0d ctl %0d ws %0d",
                 reason_tally[utfv_pkg::RSN_TRUNC], reason_tally[utfv_pkg::RSN_SCALAR],
                 reason_tally[utfv_pkg::RSN_CONTROL], reason_tally[utfv_pkg::RSN_SPACE]);
        if (fail_count == 0 && verdicts_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d verdicts never delivered", fail_count,
                     verdicts_due.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
design/utfv_pkg.sv
design/utfv_front.sv
design/utfv_queue.sv
design/utfv_back.sv
design/utf8_text_validator_unit.sv
test/tb.sv
